@@ hw/rtl/gamm_pkg.sv @@
`default_nettype none
package gamm_pkg;
    localparam int GroupsDefault  = 256;
    localparam int ColumnsDefault = 16;
    localparam int RowBitsDefault = 31;

    typedef enum logic [1:0] {
        FUNC_ACC   = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_READ3 = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        CFG_FIND_MAX = 3'd0,
        CFG_SKIP     = 3'd1,
        CFG_USE_MASK = 3'd2,
        CFG_COLS     = 3'd3,
        CFG_SINGLE   = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIPE,
        ST_READ,
        ST_UPDATE,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input transfer
        logic wipe;     // write zero entry at wipe address
        logic wipe_adv; // step wipe counter
        logic rd;       // issue slot read
        logic upd;      // compute and write back, load result
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic wipe_done;
    } dp_sts_t;

    // Total order key: true when a is strictly less than b (both non-NaN handled outside).
    function automatic logic fp_less(input logic [63:0] a, input logic [63:0] b,
                                     input logic sp);
        logic        sa, sb;
        logic [62:0] ma, mb;
        logic        za;
        begin
            if (sp) begin
                sa = a[31]; sb = b[31];
                ma = {32'd0, a[30:0]}; mb = {32'd0, b[30:0]};
            end else begin
                sa = a[63]; sb = b[63];
                ma = a[62:0]; mb = b[62:0];
            end
            za = (ma == 63'd0) && (mb == 63'd0);
            if (za) fp_less = 1'b0;
            else if (sa != sb) fp_less = sa;
            else if (sa) fp_less = ma > mb;
            else fp_less = ma < mb;
        end
    endfunction

    function automatic logic fp_nan(input logic [63:0] v, input logic sp);
        begin
            if (sp) fp_nan = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
            else    fp_nan = (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
        end
    endfunction
endpackage
`default_nettype wire

@@ hw/rtl/group_arg_min_max_core.sv @@
`default_nettype none
// Grouped arg-min/arg-max. One transfer in gives one transfer out. Each item passes
// through capture, slot RAM read, read-modify-write and result, then waits for the output;
// the registered read of the slot RAM sets these steps. After reset a clearing pass
// writes every slot (MaxGroups*MaxColumns slots, 4096 by default) before s_tready rises.
module group_arg_min_max_core
    import gamm_pkg::*;
#(
    parameter int MaxGroups  = GroupsDefault,
    parameter int MaxColumns = ColumnsDefault,
    parameter int RowBits    = RowBitsDefault
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [4:0]   cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // func[1:0], group_label[10:2], column[14:11], row_index[45:15],
    // value_bits[109:46], missing_mask[110], zero pad
    input  wire logic [111:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // best_row[31:0], slot_seen[32], zero pad
    output logic [39:0]       m_tdata
);
    logic       find_max_reg, skip_reg, mask_en_reg, single_reg;
    logic [4:0] cols_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            find_max_reg <= 1'b0;
            skip_reg     <= 1'b1;
            mask_en_reg  <= 1'b0;
            cols_reg     <= 5'd1;
            single_reg   <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_FIND_MAX: find_max_reg <= cfg_wdata[0];
                CFG_SKIP:     skip_reg     <= cfg_wdata[0];
                CFG_USE_MASK: mask_en_reg  <= cfg_wdata[0];
                CFG_COLS:     cols_reg     <= cfg_wdata;
                CFG_SINGLE:   single_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    dp_cmd_t     cmd;
    dp_sts_t     sts;
    logic [31:0] best_row;
    logic        slot_seen;

    gamm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .cmd(cmd), .sts(sts)
    );

    gamm_dp #(.MaxGroups(MaxGroups), .MaxColumns(MaxColumns), .RowBits(RowBits)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .find_max(find_max_reg), .skip_missing(skip_reg), .use_mask(mask_en_reg),
        .columns_in_use(cols_reg), .single_precision(single_reg),
        .func(s_tdata[1:0]), .group_label(s_tdata[10:2]), .column(s_tdata[14:11]),
        .row_index(s_tdata[45:15]), .value_bits(s_tdata[109:46]),
        .missing_mask(s_tdata[110]), .best_row(best_row), .slot_seen(slot_seen)
    );

    assign m_tdata = {7'd0, slot_seen, best_row};
endmodule
`default_nettype wire

@@ hw/rtl/gamm_ram.sv @@
`default_nettype none
module gamm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem_reg [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/gamm_ctrl.sv @@
`default_nettype none
module gamm_ctrl
    import gamm_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output dp_cmd_t      cmd,
    input  wire dp_sts_t sts
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_WIPE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            ST_WIPE: begin
                cmd.wipe     = 1'b1;
                cmd.wipe_adv = 1'b1;
                if (sts.wipe_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.upd    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ hw/rtl/gamm_dp.sv @@
`default_nettype none
module gamm_dp
    import gamm_pkg::*;
#(
    parameter int MaxGroups  = GroupsDefault,
    parameter int MaxColumns = ColumnsDefault,
    parameter int RowBits    = RowBitsDefault
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire dp_cmd_t       cmd,
    output dp_sts_t            sts,
    input  wire logic          find_max,
    input  wire logic          skip_missing,
    input  wire logic          use_mask,
    input  wire logic [4:0]    columns_in_use,
    input  wire logic          single_precision,
    input  wire logic [1:0]    func,
    input  wire logic [8:0]    group_label,
    input  wire logic [3:0]    column,
    input  wire logic [30:0]   row_index,
    input  wire logic [63:0]   value_bits,
    input  wire logic          missing_mask,
    output logic [31:0]        best_row,
    output logic               slot_seen
);
    localparam int Slots    = MaxGroups * MaxColumns;
    localparam int SlotBits = (Slots > 1) ? $clog2(Slots) : 1;
    localparam int EntryW   = 2 + RowBits + 64;
    localparam int LabBits  = 9;

    logic [1:0]          func_reg;
    logic                valid_reg;
    logic [SlotBits-1:0] slot_reg;
    logic [RowBits-1:0]  row_reg;
    logic [63:0]         val_reg;
    logic                mask_reg;
    logic [SlotBits:0]   wipe_cnt_reg;
    logic [31:0]         best_row_reg;
    logic                seen_reg;

    // slot address computation
    logic [4:0]  cols;
    logic [13:0] slot_wide;
    logic        in_range;
    always_comb begin
        cols = columns_in_use;
        if (cols == 5'd0) cols = 5'd1;
        if (32'(cols) > MaxColumns) cols = 5'(MaxColumns);
        slot_wide = 14'(group_label[7:0]) * 14'(cols) + 14'(column);
        in_range  = !group_label[LabBits-1] && (32'(group_label[7:0]) < MaxGroups)
                    && ({1'b0, column} < cols) && (32'(slot_wide) < Slots);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= func;
            valid_reg <= in_range;
            slot_reg  <= SlotBits'(slot_wide);
            row_reg   <= RowBits'(row_index);
            val_reg   <= value_bits;
            mask_reg  <= missing_mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wipe_cnt_reg <= '0;
        end else if (cmd.wipe_adv && !wipe_cnt_reg[SlotBits]) begin
            wipe_cnt_reg <= wipe_cnt_reg + 1'b1;
        end
    end
    assign sts.wipe_done = (wipe_cnt_reg == (SlotBits+1)'(Slots - 1));

    // entry: {seen, mark, row, value}
    logic [EntryW-1:0]   rdata, wdata;
    logic                we;
    logic [SlotBits-1:0] waddr;

    logic                e_seen, e_mark, n_seen, n_mark, missing;
    logic [RowBits-1:0]  e_row, n_row;
    logic [63:0]         e_val, n_val;
    logic                lt, gt, beats;

    always_comb begin
        {e_seen, e_mark, e_row, e_val} = rdata;
        n_seen  = e_seen;
        n_mark  = e_mark;
        n_row   = e_row;
        n_val   = e_val;
        missing = use_mask ? mask_reg : fp_nan(val_reg, single_precision);
        lt      = !fp_nan(val_reg, single_precision) && !fp_nan(e_val, single_precision)
                  && fp_less(val_reg, e_val, single_precision);
        gt      = !fp_nan(val_reg, single_precision) && !fp_nan(e_val, single_precision)
                  && fp_less(e_val, val_reg, single_precision);
        beats   = find_max ? gt : lt;
        case (func_t'(func_reg))
            FUNC_CLEAR: begin
                n_seen = 1'b0; n_mark = 1'b0; n_row = '0; n_val = '0;
            end
            FUNC_ACC: begin
                if (!(!skip_missing && e_mark)) begin
                    if (missing) begin
                        if (!skip_missing || !e_seen) n_mark = 1'b1;
                    end else if (!e_seen || beats) begin
                        n_seen = 1'b1; n_val = val_reg; n_row = row_reg; n_mark = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        if (cmd.wipe) begin
            we    = 1'b1;
            waddr = wipe_cnt_reg[SlotBits-1:0];
            wdata = '0;
        end else begin
            we    = cmd.upd && valid_reg;
            waddr = slot_reg;
            wdata = {n_seen, n_mark, n_row, n_val};
        end
    end

    gamm_ram #(.Width(EntryW), .Depth(Slots)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (slot_reg),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.upd) begin
            if (!valid_reg || func_t'(func_reg) == FUNC_CLEAR) begin
                best_row_reg <= '0;
                seen_reg     <= 1'b0;
            end else begin
                best_row_reg <= n_mark ? '1 : 32'(n_row);
                seen_reg     <= n_seen;
            end
        end
    end
    assign best_row  = best_row_reg;
    assign slot_seen = seen_reg;
endmodule
`default_nettype wire

@@ hw/rtl/gamm_checker.sv @@
`default_nettype none
module gamm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    // an unseen slot reports row zero or the missing mark
    a_unseen_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[32] |->
            (m_tdata[31:0] == 32'd0) || (m_tdata[31:0] == 32'hFFFFFFFF))
        else $error("bad row");
    a_no_result_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid) else $error("result too early");
endmodule

bind group_arg_min_max_core gamm_checker u_gamm_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
